[design/mkhid_pkg.sv]
`timescale 1ns / 1ps

package mkhid_pkg;

   // one scan holds six lines of up to eight keys, line 2y0 uses three bits
   localparam int unsigned LineCount = 6;
   localparam int unsigned LineWidth = 8;
   localparam int unsigned SlotCount = LineCount * LineWidth;
   localparam int unsigned SlotBits  = $clog2(SlotCount);

   localparam logic [SlotBits-1:0] SLOT_SLASH = SlotBits'(8);
   localparam logic [SlotBits-1:0] SLOT_ENTER = SlotBits'(18);

   localparam logic [7:0] USAGE_NONE  = 8'h00;
   localparam logic [7:0] USAGE_ENTER = 8'h28;
   localparam logic [7:0] USAGE_MINUS = 8'h2D;
   localparam logic [7:0] USAGE_A     = 8'h04;
   localparam logic [7:0] USAGE_Z     = 8'h1D;

   // hid modifier bit positions
   localparam int unsigned MOD_CTRL_BIT  = 0;
   localparam int unsigned MOD_SHIFT_BIT = 1;
   localparam int unsigned MOD_ALT_BIT   = 2;

   localparam logic [3:0] DELAY_RESET = 4'd10;

   typedef struct packed {
      logic [7:0] code;
      logic       shift;
   } fctn_map_type;

   typedef struct packed {
      logic       found;
      logic [7:0] usb_key;
      logic [2:0] hid_mod;
   } xlate_type;

   function automatic logic [7:0] plain_usage(input logic [SlotBits-1:0] slot);
      logic [7:0] code;
      code = USAGE_NONE;
      unique case (slot)
         // N H Y 6 5 G T B
         6'd0:  code = 8'h11;
         6'd1:  code = 8'h0B;
         6'd2:  code = 8'h1C;
         6'd3:  code = 8'h23;
         6'd4:  code = 8'h22;
         6'd5:  code = 8'h0A;
         6'd6:  code = 8'h17;
         6'd7:  code = 8'h05;
         // / ; P 0 1 A Q Z
         6'd8:  code = 8'h38;
         6'd9:  code = 8'h33;
         6'd10: code = 8'h13;
         6'd11: code = 8'h27;
         6'd12: code = 8'h1E;
         6'd13: code = 8'h04;
         6'd14: code = 8'h14;
         6'd15: code = 8'h1D;
         // = space enter
         6'd16: code = 8'h2E;
         6'd17: code = 8'h2C;
         6'd18: code = USAGE_ENTER;
         // . L O 9 2 S W X
         6'd24: code = 8'h37;
         6'd25: code = 8'h0F;
         6'd26: code = 8'h12;
         6'd27: code = 8'h26;
         6'd28: code = 8'h1F;
         6'd29: code = 8'h16;
         6'd30: code = 8'h1A;
         6'd31: code = 8'h1B;
         // , K I 8 3 D E C
         6'd32: code = 8'h36;
         6'd33: code = 8'h0E;
         6'd34: code = 8'h0C;
         6'd35: code = 8'h25;
         6'd36: code = 8'h20;
         6'd37: code = 8'h07;
         6'd38: code = 8'h08;
         6'd39: code = 8'h06;
         // M J U 7 4 F R V
         6'd40: code = 8'h10;
         6'd41: code = 8'h0D;
         6'd42: code = 8'h18;
         6'd43: code = 8'h24;
         6'd44: code = 8'h21;
         6'd45: code = 8'h09;
         6'd46: code = 8'h15;
         6'd47: code = 8'h19;
         default: code = USAGE_NONE;
      endcase
      return code;
   endfunction

   // fctn combinations, code zero where the key has none
   function automatic fctn_map_type fctn_usage(input logic [SlotBits-1:0] slot);
      fctn_map_type m;
      m = '{code: USAGE_NONE, shift: 1'b0};
      unique case (slot)
         6'd13: m = '{code: 8'h31, shift: 1'b1}; // A
         6'd39: m = '{code: 8'h35, shift: 1'b0}; // C
         6'd37: m = '{code: 8'h4F, shift: 1'b0}; // D
         6'd38: m = '{code: 8'h52, shift: 1'b0}; // E
         6'd45: m = '{code: 8'h2F, shift: 1'b1}; // F
         6'd5:  m = '{code: 8'h30, shift: 1'b1}; // G
         6'd34: m = '{code: 8'h38, shift: 1'b1}; // I
         6'd26: m = '{code: 8'h34, shift: 1'b0}; // O
         6'd10: m = '{code: 8'h34, shift: 1'b1}; // P
         6'd46: m = '{code: 8'h2F, shift: 1'b0}; // R
         6'd29: m = '{code: 8'h50, shift: 1'b0}; // S
         6'd6:  m = '{code: 8'h30, shift: 1'b0}; // T
         6'd42: m = '{code: 8'h2D, shift: 1'b1}; // U
         6'd30: m = '{code: 8'h35, shift: 1'b1}; // W
         6'd31: m = '{code: 8'h51, shift: 1'b0}; // X
         6'd15: m = '{code: 8'h31, shift: 1'b0}; // Z
         default: m = '{code: USAGE_NONE, shift: 1'b0};
      endcase
      return m;
   endfunction

endpackage

[design/mkhid_xlate.sv]
`timescale 1ns / 1ps

module mkhid_xlate (
   input  logic                    caps_pressed,
   input  logic                    shift_pressed,
   input  logic                    ctrl_pressed,
   input  logic                    fctn_pressed,
   input  logic [7:0]              line_1y0_keys,
   input  logic [7:0]              line_1y1_keys,
   input  logic [2:0]              line_2y0_keys,
   input  logic [7:0]              line_2y1_keys,
   input  logic [7:0]              line_2y2_keys,
   input  logic [7:0]              line_2y3_keys,
   output mkhid_pkg::xlate_type    result
);
   import mkhid_pkg::*;

   localparam int unsigned BitSel  = $clog2(LineWidth);
   localparam int unsigned LineSel = SlotBits - BitSel;

   logic [LineWidth-1:0] lines [LineCount];
   logic [LineCount-1:0] line_hit;
   logic [BitSel-1:0]    line_first [LineCount];
   logic [LineSel-1:0]   sel_line;
   logic [BitSel-1:0]    sel_bit;
   logic [SlotBits-1:0]  slot;
   logic [7:0]           plain;
   fctn_map_type         fmap;
   logic                 is_letter;
   logic                 alt;
   logic                 shift_used;
   logic [7:0]           code;
   logic                 shift_bit;

   always_comb begin
      lines[0] = line_1y0_keys;
      lines[1] = line_1y1_keys;
      lines[2] = {5'b0, line_2y0_keys};
      lines[3] = line_2y1_keys;
      lines[4] = line_2y2_keys;
      lines[5] = line_2y3_keys;
   end

   // lowest pressed bit within each line
   always_comb begin
      for (int l = 0; l < LineCount; l++) begin
         line_hit[l]   = |lines[l];
         line_first[l] = '0;
         for (int b = LineWidth - 1; b >= 0; b--) begin
            if (lines[l][b]) line_first[l] = BitSel'(b);
         end
      end
   end

   // first line with any key down
   always_comb begin
      sel_line = '0;
      sel_bit  = '0;
      for (int l = LineCount - 1; l >= 0; l--) begin
         if (line_hit[l]) begin
            sel_line = LineSel'(l);
            sel_bit  = line_first[l];
         end
      end
   end

   assign slot      = {sel_line, sel_bit};
   assign plain     = plain_usage(slot);
   assign fmap      = fctn_usage(slot);
   assign is_letter = (plain >= USAGE_A) && (plain <= USAGE_Z);

   always_comb begin
      code       = plain;
      shift_bit  = 1'b0;
      alt        = fctn_pressed;
      shift_used = 1'b0;
      priority if (slot == SLOT_ENTER) begin
         code = USAGE_ENTER;
      end else if (fctn_pressed && (fmap.code != USAGE_NONE)) begin
         // mapped fctn combination replaces alt
         code      = fmap.code;
         shift_bit = fmap.shift;
         alt       = 1'b0;
      end else if ((slot == SLOT_SLASH) && shift_pressed) begin
         // shifted slash is a bare minus
         code       = USAGE_MINUS;
         shift_used = 1'b1;
      end else begin
         shift_bit = caps_pressed && is_letter;
      end
   end

   always_comb begin
      result.found   = |line_hit;
      result.usb_key = code;
      result.hid_mod = '0;
      result.hid_mod[MOD_CTRL_BIT]  = ctrl_pressed;
      result.hid_mod[MOD_SHIFT_BIT] = shift_bit || (shift_pressed && !shift_used);
      result.hid_mod[MOD_ALT_BIT]   = alt;
   end

endmodule

[design/mkhid_repeat.sv]
`timescale 1ns / 1ps

module mkhid_repeat (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  mkhid_pkg::xlate_type    xlate,
   input  logic                    tenth_tick,
   input  logic [3:0]              repeat_delay,
   output logic                    emit
);
   import mkhid_pkg::*;

   logic [7:0] last_key_ff;
   logic [7:0] last_key_in;
   logic [2:0] last_mod_ff;
   logic [2:0] last_mod_in;
   logic [3:0] count_ff;
   logic [3:0] count_in;
   logic       changed;
   logic       at_limit;

   assign changed  = (last_key_ff != xlate.usb_key) || (last_mod_ff != xlate.hid_mod);
   assign at_limit = count_ff >= repeat_delay;
   assign emit     = xlate.found && (changed || at_limit);

   always_comb begin
      last_key_in = last_key_ff;
      last_mod_in = last_mod_ff;
      count_in    = count_ff;
      if (advance) begin
         if (!xlate.found) begin
            last_key_in = '0;
            last_mod_in = '0;
            count_in    = '0;
         end else begin
            last_key_in = xlate.usb_key;
            last_mod_in = xlate.hid_mod;
            // below the limit, so the increment cannot wrap
            if (!emit && tenth_tick) count_in = count_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_key_ff <= '0;
         last_mod_ff <= '0;
         count_ff    <= '0;
      end else begin
         last_key_ff <= last_key_in;
         last_mod_ff <= last_mod_in;
         count_ff    <= count_in;
      end
   end

endmodule

[design/matrix_key_to_usb_hid_translator.sv]
`timescale 1ns / 1ps

// channel | direction | handshake               | payload
// req     | in        | req_tvalid / req_tready | req_tdata[47:0]  one matrix scan
// rsp     | out       | rsp_tvalid / rsp_tready | rsp_tdata[15:0]  key press
// csr     | in        | csr_valid / csr_ready   | csr_data[3:0]    repeat delay
//
// a request is registered, then translated and checked against the held key;
// a press lands in the result register when the input register advances.
// one request per cycle is sustained while rsp is not stalled; the input
// register advances whenever the result register is empty or being taken, so
// a stall on rsp holds at most one request in the input register. reset clears
// the held key, the repeat counter and both valid flags, and loads a repeat
// delay of ten ticks. csr_ready is always high.

module matrix_key_to_usb_hid_translator (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // caps, shift, ctrl, fctn, line_1y0_keys[8], line_1y1_keys[8], line_2y0_keys[3],
   // line_2y1_keys[8], line_2y2_keys[8], line_2y3_keys[8], tenth_tick
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // usb_key[8], hid_mod[3], zero fill[5]
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [3:0]  csr_data
);
   import mkhid_pkg::*;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [47:0] in_data_ff;
   logic [47:0] in_data_in;
   logic        out_valid_ff;
   logic        out_valid_in;
   logic [7:0]  out_key_ff;
   logic [7:0]  out_key_in;
   logic [2:0]  out_mod_ff;
   logic [2:0]  out_mod_in;
   logic [3:0]  delay_ff;
   logic [3:0]  delay_in;
   logic        advance;
   logic        req_take;
   logic        emit;
   xlate_type   xlate;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   mkhid_xlate u_xlate (
      .caps_pressed  (in_data_ff[0]),
      .shift_pressed (in_data_ff[1]),
      .ctrl_pressed  (in_data_ff[2]),
      .fctn_pressed  (in_data_ff[3]),
      .line_1y0_keys (in_data_ff[11:4]),
      .line_1y1_keys (in_data_ff[19:12]),
      .line_2y0_keys (in_data_ff[22:20]),
      .line_2y1_keys (in_data_ff[30:23]),
      .line_2y2_keys (in_data_ff[38:31]),
      .line_2y3_keys (in_data_ff[46:39]),
      .result        (xlate)
   );

   mkhid_repeat u_repeat (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .xlate        (xlate),
      .tenth_tick   (in_data_ff[47]),
      .repeat_delay (delay_ff),
      .emit         (emit)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_data_in  = req_tdata;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_key_in   = out_key_ff;
      out_mod_in   = out_mod_ff;
      if (advance) begin
         out_valid_in = emit;
         out_key_in   = xlate.usb_key;
         out_mod_in   = xlate.hid_mod;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign delay_in = (csr_valid && csr_ready) ? csr_data : delay_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         delay_ff     <= DELAY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         delay_ff     <= delay_in;
      end
      in_data_ff <= in_data_in;
      out_key_ff <= out_key_in;
      out_mod_ff <= out_mod_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_mod_ff, out_key_ff};

   // input stage only blocks while a press waits downstream
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && out_valid_ff && !rsp_tready))
      else $error("input stage blocked without a downstream stall");

   // every press carries a real usage code
   a_press_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] != USAGE_NONE))
      else $error("press with empty usage code");

   // a press only appears after a translated request moved forward
   a_press_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(advance))
      else $error("press without a request behind it");

endmodule
